FILE: src/timestamp_pair_matcher_assert.svh
// Assertion macros for the timestamp pair matcher.
// Used by the top level only.
`ifndef TIMESTAMP_PAIR_MATCHER_ASSERT_SVH
`define TIMESTAMP_PAIR_MATCHER_ASSERT_SVH
// Implication checked on every rising clock edge, disabled in reset.
`define TPM_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define TPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: src/tpm_pkg.sv
// Package for the timestamp pair matcher: widths, constants, control structs.
// No dependencies.
package tpm_pkg;
   localparam int TIME_W = 48;
   localparam int WIN_W = 20;
   localparam int FIX_DEPTH_DEF = 16;
   localparam int PULSE_DEPTH_DEF = 8;
   localparam int MAX_RESULTS = 16;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 20'd50000;
   localparam logic OP_SYNC = 1'b0;
   localparam logic OP_FIX = 1'b1;
   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_LOST = 1'b1;

   // Controller to datapath commands.
   typedef struct packed {
      logic push_pulse;   // store request as pulse
      logic push_fix;     // store request as fix
      logic load_fix;     // latch current fix entry (index f)
      logic load_pulse;   // latch pulse entry (index p)
      logic next_pulse;   // p++, count scanned
      logic start_fix;    // reset p/scanned for new fix
      logic emit_match;   // build match result, pop scanned pulses
      logic emit_lost;    // build lost result, pop scanned pulses
      logic drop_fix;     // fix done, no result
      logic clear_pulse;  // clear pulse queue
      logic finish;       // pop done fixes
      logic mark_last;    // flag result as final
   } tpm_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic fix_left;     // f < fix count and results < max
      logic pulse_left;   // p < pulse count
      logic behind;       // fix + w < pulse
      logic in_window;    // fix < pulse + w
      logic none_scanned;
      logic any_result;
   } tpm_sts_type;
endpackage

FILE: src/tpm_datapath.sv
// Datapath of the timestamp pair matcher: queues, scan pointers, compare, result.
// Depends on tpm_pkg.
module tpm_datapath import tpm_pkg::*; #(
   parameter int FIX_DEPTH = FIX_DEPTH_DEF,
   parameter int PULSE_DEPTH = PULSE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  tpm_cmd_type       cmd,
   output tpm_sts_type       sts,
   input  logic [WIN_W-1:0]  window,
   input  logic [TIME_W-1:0] in_sys,
   input  logic [TIME_W-1:0] in_stamp,
   input  logic [TIME_W-1:0] in_utc,
   output logic              res_kind,
   output logic [TIME_W-1:0] res_stamp,
   output logic [TIME_W-1:0] res_psys,
   output logic [TIME_W-1:0] res_utc,
   output logic [TIME_W-1:0] res_fsys,
   output logic              res_last
);
   localparam int FA = $clog2(FIX_DEPTH);
   localparam int PA = $clog2(PULSE_DEPTH);
   localparam int FC = $clog2(FIX_DEPTH + 1);
   localparam int PC = $clog2(PULSE_DEPTH + 1);
   localparam int RC = $clog2(MAX_RESULTS + 1);

   logic [TIME_W-1:0] fix_time_mem [FIX_DEPTH];
   logic [TIME_W-1:0] fix_utc_mem [FIX_DEPTH];
   logic [TIME_W-1:0] pulse_time_mem [PULSE_DEPTH];
   logic [TIME_W-1:0] pulse_stamp_mem [PULSE_DEPTH];

   logic [FA-1:0] fix_head_ff;
   logic [FC-1:0] fix_count_ff, fix_idx_ff, fix_done_ff;
   logic [PA-1:0] pulse_head_ff;
   logic [PC-1:0] pulse_count_ff, pulse_idx_ff;
   logic [RC-1:0] res_count_ff;
   logic [TIME_W-1:0] cur_ft_ff, cur_fu_ff, cur_pt_ff, cur_ps_ff;
   logic [TIME_W-1:0] align_imu_ff, align_fix_ff;

   // Wrapped addresses.
   function automatic logic [FA-1:0] fwrap(input logic [FA-1:0] h, input logic [FC-1:0] o);
      logic [FC:0] s;
      s = {1'b0, {(FC-FA){1'b0}}, h} + {1'b0, o};
      if (s >= (FC+1)'(FIX_DEPTH)) s = s - (FC+1)'(FIX_DEPTH);
      return s[FA-1:0];
   endfunction
   function automatic logic [PA-1:0] pwrap(input logic [PA-1:0] h, input logic [PC-1:0] o);
      logic [PC:0] s;
      s = {1'b0, {(PC-PA){1'b0}}, h} + {1'b0, o};
      if (s >= (PC+1)'(PULSE_DEPTH)) s = s - (PC+1)'(PULSE_DEPTH);
      return s[PA-1:0];
   endfunction

   logic fix_full, pulse_full;
   assign fix_full = fix_count_ff == FC'(FIX_DEPTH);
   assign pulse_full = pulse_count_ff == PC'(PULSE_DEPTH);

   // Compares on 49-bit sums.
   logic [TIME_W:0] ft_plus_w, pt_plus_w;
   assign ft_plus_w = {1'b0, cur_ft_ff} + (TIME_W+1)'(window);
   assign pt_plus_w = {1'b0, cur_pt_ff} + (TIME_W+1)'(window);
   assign sts.behind = ft_plus_w < {1'b0, cur_pt_ff};
   assign sts.in_window = {1'b0, cur_ft_ff} < pt_plus_w;
   assign sts.fix_left = (fix_idx_ff < fix_count_ff) && (res_count_ff < RC'(MAX_RESULTS));
   assign sts.pulse_left = pulse_idx_ff < pulse_count_ff;
   assign sts.none_scanned = pulse_idx_ff == '0;
   assign sts.any_result = res_count_ff != '0;

   // Queue storage writes and reads.
   always_ff @(posedge clock) begin
      if (cmd.push_fix) begin
         fix_time_mem[fwrap(fix_head_ff, fix_full ? FC'(0) : fix_count_ff)] <= in_sys;
      end
      if (cmd.push_pulse) begin
         pulse_time_mem[pwrap(pulse_head_ff, pulse_full ? PC'(0) : pulse_count_ff)] <= in_sys;
         pulse_stamp_mem[pwrap(pulse_head_ff, pulse_full ? PC'(0) : pulse_count_ff)] <= in_stamp;
      end
      if (cmd.push_fix)
         fix_utc_mem[fwrap(fix_head_ff, fix_full ? FC'(0) : fix_count_ff)] <= in_utc;
      if (cmd.load_fix) begin
         cur_ft_ff <= fix_time_mem[fwrap(fix_head_ff, fix_idx_ff)];
         cur_fu_ff <= fix_utc_mem[fwrap(fix_head_ff, fix_idx_ff)];
      end
      if (cmd.load_pulse) begin
         cur_pt_ff <= pulse_time_mem[pwrap(pulse_head_ff, pulse_idx_ff)];
         cur_ps_ff <= pulse_stamp_mem[pwrap(pulse_head_ff, pulse_idx_ff)];
      end
   end

   // Pointers and counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         fix_head_ff <= '0; fix_count_ff <= '0; fix_idx_ff <= '0; fix_done_ff <= '0;
         pulse_head_ff <= '0; pulse_count_ff <= '0; pulse_idx_ff <= '0;
         res_count_ff <= '0; align_imu_ff <= '0; align_fix_ff <= '0;
      end else begin
         if (cmd.push_pulse) begin
            if (pulse_full) pulse_head_ff <= pwrap(pulse_head_ff, PC'(1));
            else pulse_count_ff <= pulse_count_ff + PC'(1);
         end
         if (cmd.push_fix) begin
            if (fix_full) fix_head_ff <= fwrap(fix_head_ff, FC'(1));
            else fix_count_ff <= fix_count_ff + FC'(1);
            fix_idx_ff <= '0;
            fix_done_ff <= '0;
            res_count_ff <= '0;
         end
         if (cmd.start_fix) pulse_idx_ff <= '0;
         if (cmd.next_pulse) pulse_idx_ff <= pulse_idx_ff + PC'(1);
         if (cmd.emit_match || cmd.emit_lost) begin
            pulse_head_ff <= pwrap(pulse_head_ff, pulse_idx_ff);
            pulse_count_ff <= pulse_count_ff - pulse_idx_ff;
            res_count_ff <= res_count_ff + RC'(1);
         end
         if (cmd.emit_match) begin
            align_imu_ff <= cur_ps_ff;
            align_fix_ff <= cur_ft_ff;
         end
         if (cmd.emit_match || cmd.emit_lost || cmd.drop_fix) begin
            fix_idx_ff <= fix_idx_ff + FC'(1);
            fix_done_ff <= fix_done_ff + FC'(1);
         end
         if (cmd.clear_pulse) begin
            pulse_head_ff <= '0;
            pulse_count_ff <= '0;
         end
         if (cmd.finish) begin
            fix_head_ff <= fwrap(fix_head_ff, fix_done_ff);
            fix_count_ff <= fix_count_ff - fix_done_ff;
         end
      end
   end

   // Result register; match counts the current pulse as scanned.
   always_ff @(posedge clock) begin
      if (cmd.emit_match) begin
         res_kind <= KIND_MATCH;
         res_stamp <= cur_ps_ff;
         res_psys <= cur_pt_ff;
      end
      if (cmd.emit_lost) begin
         res_kind <= KIND_LOST;
         res_stamp <= '0;
         res_psys <= '0;
      end
      if (cmd.emit_match || cmd.emit_lost) begin
         res_utc <= cur_fu_ff;
         res_fsys <= cur_ft_ff;
      end
      if (cmd.emit_match || cmd.emit_lost) res_last <= 1'b0;
      else if (cmd.mark_last) res_last <= 1'b1;
   end
endmodule

FILE: src/tpm_control.sv
// Controller of the timestamp pair matcher: sequences the scan and handshakes.
// Depends on tpm_pkg.
module tpm_control import tpm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  tpm_sts_type sts,
   output tpm_cmd_type cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIX   = 3'd1;
   localparam logic [2:0] S_PLOAD = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_HOLD  = 3'd4;
   localparam logic [2:0] S_END   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic out_ff, out_in;   // result held, not yet shown
   logic pend_ff, pend_in; // result shown, waiting for the transaction

   assign req_ready = state_ff == S_IDLE && !pend_ff;
   assign rsp_valid = pend_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      out_in = out_ff;
      pend_in = pend_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_operation == OP_SYNC) cmd.push_pulse = 1'b1;
               else begin
                  cmd.push_fix = 1'b1;
                  state_in = S_FIX;
               end
            end
         end
         S_FIX: begin
            if (sts.fix_left) begin
               cmd.load_fix = 1'b1;
               cmd.start_fix = 1'b1;
               state_in = S_PLOAD;
            end else state_in = S_END;
         end
         S_PLOAD: begin
            if (sts.pulse_left) begin
               cmd.load_pulse = 1'b1;
               state_in = S_CMP;
            end else if (sts.none_scanned) begin
               cmd.clear_pulse = 1'b1; // empty queue: fix ahead
               state_in = S_END;
            end else begin
               cmd.clear_pulse = 1'b1;
               state_in = S_END;
            end
         end
         S_CMP: begin
            if (sts.behind) begin
               if (sts.none_scanned) begin
                  cmd.drop_fix = 1'b1;
                  state_in = S_FIX;
               end else if (out_ff) begin
                  // a successor exists: show the held result first
                  pend_in = 1'b1;
                  out_in = 1'b0;
               end else if (!pend_ff) begin
                  cmd.emit_lost = 1'b1;
                  out_in = 1'b1;
                  state_in = S_FIX;
               end
            end else begin
               cmd.next_pulse = 1'b1;
               if (sts.in_window) begin
                  state_in = S_HOLD;
               end else state_in = S_PLOAD;
            end
         end
         S_HOLD: begin
            if (out_ff) begin
               pend_in = 1'b1;
               out_in = 1'b0;
            end else if (!pend_ff) begin
               cmd.emit_match = 1'b1;
               out_in = 1'b1;
               state_in = S_FIX;
            end
         end
         S_END: begin
            if (out_ff) begin
               cmd.mark_last = 1'b1;
               pend_in = 1'b1;
               out_in = 1'b0;
            end else if (!pend_ff) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
         pend_ff <= pend_in;
      end
   end
endmodule

FILE: src/timestamp_pair_matcher.sv
// Top level of the timestamp pair matcher: window register, controller, datapath.
// Depends on tpm_pkg, tpm_control, tpm_datapath and the assertion header.
//
//  channel  direction  contents
//  req_     in         operation, sys_time, imu_stamp, fix_utc
//  rsp_     out        kind, two pulse stamps, two fix stamps, last
//  csr_     in         match_window
//
// A fix transaction walks the pending fixes one at a time and, for each, the
// queued pulses one entry at a time; no new request is taken until the scan
// has ended and its last result has been taken; at most 16 x 8 pulse
// compares.
// Reset (synchronous) empties both queues and loads the window with 50000.
// A result is held until its successor or the end is known; a stalled result
// holds the scan until it is taken.
`include "timestamp_pair_matcher_assert.svh"
module timestamp_pair_matcher import tpm_pkg::*; #(
   parameter int FIX_DEPTH = FIX_DEPTH_DEF,
   parameter int PULSE_DEPTH = PULSE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [TIME_W-1:0] req_sys_time,
   input  logic [TIME_W-1:0] req_imu_stamp,
   input  logic [TIME_W-1:0] req_fix_utc,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [TIME_W-1:0] rsp_matched_imu_stamp,
   output logic [TIME_W-1:0] rsp_matched_imu_sys,
   output logic [TIME_W-1:0] rsp_matched_utc,
   output logic [TIME_W-1:0] rsp_matched_fix_sys,
   output logic              rsp_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WIN_W-1:0]  csr_match_window
);
   tpm_cmd_type cmd;
   tpm_sts_type sts;
   logic [WIN_W-1:0] window_ff;

   assign csr_ready = 1'b1;

   // Window register.
   always_ff @(posedge clock) begin
      if (reset) window_ff <= WINDOW_RESET;
      else if (csr_valid) window_ff <= csr_match_window;
   end

   tpm_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_operation,
      .rsp_valid, .rsp_ready, .sts, .cmd
   );

   tpm_datapath #(.FIX_DEPTH(FIX_DEPTH), .PULSE_DEPTH(PULSE_DEPTH)) u_datapath (
      .clock, .reset, .cmd, .sts, .window(window_ff),
      .in_sys(req_sys_time), .in_stamp(req_imu_stamp), .in_utc(req_fix_utc),
      .res_kind(rsp_kind), .res_stamp(rsp_matched_imu_stamp),
      .res_psys(rsp_matched_imu_sys), .res_utc(rsp_matched_utc),
      .res_fsys(rsp_matched_fix_sys), .res_last(rsp_last)
   );

   `TPM_ASSERT_IMPL(a_no_accept_busy, rsp_valid, !req_ready, "input taken with result pending")
   `TPM_ASSERT_IMPL(a_lost_zero, rsp_valid && rsp_kind == KIND_LOST, rsp_matched_imu_stamp == '0, "lost result carries stamp")
   `TPM_ASSERT_NEXT(a_sync_no_work, req_valid && req_ready && req_operation == OP_SYNC, req_ready || !req_valid || rsp_valid == 1'b0, "sync started a scan")
endmodule

FILE: verif/tpm_checker.sv
// Checker for the timestamp pair matcher: watches the request, result and
// window channels, predicts results and compares them. Depends on tpm_pkg.
module tpm_checker import tpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_operation,
   input  logic [TIME_W-1:0] req_sys_time,
   input  logic [TIME_W-1:0] req_imu_stamp,
   input  logic [TIME_W-1:0] req_fix_utc,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_kind,
   input  logic [TIME_W-1:0] rsp_matched_imu_stamp,
   input  logic [TIME_W-1:0] rsp_matched_imu_sys,
   input  logic [TIME_W-1:0] rsp_matched_utc,
   input  logic [TIME_W-1:0] rsp_matched_fix_sys,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [WIN_W-1:0]  csr_match_window,
   output int                mismatches,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] imu_stamp;
      logic [TIME_W-1:0] imu_sys;
      logic [TIME_W-1:0] utc;
      logic [TIME_W-1:0] fix_sys;
      logic              last;
   } pair_result_type;

   localparam int FIXES = FIX_DEPTH_DEF;
   localparam int PULSES = PULSE_DEPTH_DEF;

   pair_result_type expected_pairs[$];

   // Predictor state
   logic [WIN_W-1:0]  window;
   logic [TIME_W-1:0] fix_sys_q[FIXES];
   logic [TIME_W-1:0] fix_utc_q[FIXES];
   int                fix_head, fix_count;
   logic [TIME_W-1:0] pulse_sys_q[PULSES];
   logic [TIME_W-1:0] pulse_stamp_q[PULSES];
   int                pulse_head, pulse_count;
   logic [TIME_W-1:0] align_imu, align_fix;

   assign outstanding = expected_pairs.size();

   task automatic pop_pulses(input int n);
      if (n > pulse_count) n = pulse_count;
      pulse_head = (pulse_head + n) % PULSES;
      pulse_count -= n;
   endtask

   // Queue the fix, then rescan all pending fixes against the pulse queue
   task automatic match_pending_fixes(input logic [TIME_W-1:0] sys,
                                      input logic [TIME_W-1:0] utc);
      int done, nres, scanned, hit, fi, pi;
      bit found, ahead;
      longint unsigned ft, pt, w;
      pair_result_type r;
      done = 0;
      nres = 0;
      ahead = 0;
      w = window;
      if (fix_count >= FIXES) begin
         fix_head = (fix_head + 1) % FIXES;
         fix_count--;
      end
      fix_sys_q[(fix_head + fix_count) % FIXES] = sys;
      fix_utc_q[(fix_head + fix_count) % FIXES] = utc;
      fix_count++;
      for (int f = 0; f < fix_count && nres < MAX_RESULTS && !ahead; f++) begin
         fi = (fix_head + f) % FIXES;
         ft = fix_sys_q[fi];
         scanned = 0;
         found = 0;
         hit = 0;
         for (int p = 0; p < pulse_count; p++) begin
            pi = (pulse_head + p) % PULSES;
            pt = pulse_sys_q[pi];
            if (ft + w < pt) break;
            scanned++;
            if (ft < pt + w) begin
               found = 1;
               hit = pi;
               break;
            end
         end
         if (found) begin
            align_imu = pulse_stamp_q[hit];
            align_fix = ft;
            r = '{KIND_MATCH, pulse_stamp_q[hit], pulse_sys_q[hit], fix_utc_q[fi],
                  fix_sys_q[fi], 1'b0};
            expected_pairs.push_back(r);
            nres++;
            pop_pulses(scanned);
            done++;
         end else if (scanned == pulse_count) begin
            // fix is ahead of every pulse: flush pulses, keep it pending
            pulse_head = 0;
            pulse_count = 0;
            ahead = 1;
         end else if (scanned == 0) begin
            done++;
         end else begin
            r = '{KIND_LOST, '0, '0, fix_utc_q[fi], fix_sys_q[fi], 1'b0};
            expected_pairs.push_back(r);
            nres++;
            pop_pulses(scanned);
            done++;
         end
      end
      fix_head = (fix_head + done) % FIXES;
      fix_count -= done;
      if (nres > 0) expected_pairs[expected_pairs.size() - 1].last = 1'b1;
   endtask

   // Compare results first, then predict from the request of the same edge
   always @(posedge clock) begin
      pair_result_type want;
      if (reset) begin
         window <= WINDOW_RESET;
         fix_head = 0;
         fix_count = 0;
         pulse_head = 0;
         pulse_count = 0;
         align_imu = '0;
         align_fix = '0;
         expected_pairs.delete();
         mismatches <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pairs.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%t: result transaction with none expected", $realtime);
            end else begin
               want = expected_pairs[0];
               expected_pairs.delete(0);
               if (want !== {rsp_kind, rsp_matched_imu_stamp, rsp_matched_imu_sys,
                             rsp_matched_utc, rsp_matched_fix_sys, rsp_last}) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"%t: expected kind %0d stamp %h sys %h utc %h fix %h",
                               " last %0d, got kind %0d stamp %h sys %h utc %h",
                               " fix %h last %0d"},
                        $realtime, want.kind, want.imu_stamp, want.imu_sys,
                        want.utc, want.fix_sys, want.last, rsp_kind,
                        rsp_matched_imu_stamp, rsp_matched_imu_sys,
                        rsp_matched_utc, rsp_matched_fix_sys, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_operation == OP_SYNC) begin
               if (pulse_count >= PULSES) pop_pulses(1);
               pulse_sys_q[(pulse_head + pulse_count) % PULSES] = req_sys_time;
               pulse_stamp_q[(pulse_head + pulse_count) % PULSES] = req_imu_stamp;
               pulse_count++;
            end else begin
               match_pending_fixes(req_sys_time, req_fix_utc);
            end
         end
         if (csr_valid && csr_ready) window <= csr_match_window;
      end
   end
endmodule

FILE: verif/tb_top.sv
// Testbench top for the timestamp pair matcher: clock, reset, stimulus and verdict.
// Depends on tpm_pkg, timestamp_pair_matcher and tpm_checker.
module tb_top;
   import tpm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCAN_CYCLES = 320;    // worst fix scan with no result
   localparam int STALL_LIMIT = 20000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0, req_ready;
   logic              req_operation = OP_SYNC;
   logic [TIME_W-1:0] req_sys_time = '0, req_imu_stamp = '0, req_fix_utc = '0;
   logic              rsp_valid, rsp_ready = 0, rsp_kind, rsp_last;
   logic [TIME_W-1:0] rsp_matched_imu_stamp, rsp_matched_imu_sys;
   logic [TIME_W-1:0] rsp_matched_utc, rsp_matched_fix_sys;
   logic              csr_valid = 0, csr_ready;
   logic [WIN_W-1:0]  csr_match_window = '0;
   logic              req_took = 0, rsp_took = 0, csr_took = 0;
   int                mismatches, outstanding, quiet_cycles = 0;
   longint unsigned   now_us, win_us;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   timestamp_pair_matcher dut (.*);

   tpm_checker u_checker (.*);

   // Handshake flags, stable by the falling edge
   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
      csr_took <= csr_valid && csr_ready;
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side back-pressure, with stretches of none
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_ready <= 0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(negedge clock); while (!rsp_took);
      end
   end

   function automatic logic [TIME_W-1:0] rand48();
      return TIME_W'({$urandom, $urandom});
   endfunction

   // One request transaction; called and returns at a falling edge
   task automatic send(input logic op, input logic [TIME_W-1:0] sys,
                       input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] utc);
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_sys_time <= sys;
      req_imu_stamp <= stamp;
      req_fix_utc <= utc;
      do @(negedge clock); while (!req_took);
   endtask

   // Window write once the block has drained
   task automatic set_window(input logic [WIN_W-1:0] w);
      req_valid <= 0;
      while (outstanding != 0) @(negedge clock);
      repeat (SCAN_CYCLES) @(negedge clock);
      csr_valid <= 1;
      csr_match_window <= w;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 0;
      win_us = w;
   endtask

   // Stream of items near a moving time cursor, with fix bursts and noise
   task automatic random_phase(input int n);
      int kind, burst;
      logic op;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            send(1'($urandom_range(0, 1)), rand48(), rand48(), rand48());
         end else if (kind < 12) begin
            burst = $urandom_range(4, 18);
            for (int b = 0; b < burst; b++) begin
               now_us += $urandom_range(0, 3 * win_us / 2 + 2);
               send(OP_FIX, now_us[TIME_W-1:0], rand48(), rand48());
            end
            i += burst - 1;
         end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_SYNC : OP_FIX;
            now_us += $urandom_range(0, win_us + win_us / 2 + 2);
            send(op, now_us[TIME_W-1:0], rand48(), rand48());
         end
         if (now_us > 48'hF000_0000_0000) now_us = $urandom_range(0, 1000);
      end
   endtask

   initial begin
      win_us = WINDOW_RESET;
      now_us = 64'd1_000_000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: reset window of 50000
      send(OP_FIX, 48'd0, '0, 48'd11);               // no pulses: stays pending
      send(OP_SYNC, 48'd1_000_000, 48'h1, '0);
      send(OP_FIX, 48'd1_000_000, '0, 48'd12);       // old fix dropped, new one matches
      send(OP_SYNC, 48'd2_000_000, 48'h2, '0);
      send(OP_SYNC, 48'd2_200_000, 48'h3, '0);
      send(OP_FIX, 48'd2_200_000, '0, 48'd13);       // skips first pulse, matches second
      send(OP_SYNC, 48'd3_000_000, 48'h4, '0);
      send(OP_SYNC, 48'd3_500_000, 48'h5, '0);
      send(OP_FIX, 48'd3_200_000, '0, 48'd14);       // lost its pulse
      send(OP_SYNC, 48'd4_000_000, 48'h6, '0);
      send(OP_FIX, 48'd5_000_000, '0, 48'd15);       // ahead of all: flush pulses
      send(OP_SYNC, 48'd5_010_000, 48'h7, '0);
      send(OP_FIX, 48'd5_020_000, '0, 48'd16);       // pending fix matches, new one stays pending
      for (int k = 0; k < 9; k++)                    // pulse queue overflow
         send(OP_SYNC, 48'd6_000_000 + TIME_W'(k * 10), {TIME_W{k[0]}}, '0);
      send(OP_FIX, 48'd6_000_050, '1, '1);
      send(OP_SYNC, '1, '1, '1);
      send(OP_FIX, '1, '0, '1);                      // match at top of time range

      // Random phases across window settings, extremes included
      set_window(20'd1_000_000);
      random_phase(85);
      set_window(20'd0);
      random_phase(70);
      set_window('1);
      random_phase(85);
      set_window(20'($urandom_range(1, 200_000)));
      random_phase(90);
      set_window(20'd50_000);
      random_phase(100);

      req_valid <= 0;
      while (outstanding != 0) @(negedge clock);
      repeat (SCAN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
